/* rtl/multi_char_delimiter_splitter_defines.svh */
// Assertion macros for the delimiter splitter.
// Included by the top level; define NO_ASSERTIONS to compile them out.
`ifndef MULTI_CHAR_DELIMITER_SPLITTER_DEFINES_SVH
`define MULTI_CHAR_DELIMITER_SPLITTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MCDS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcds: same-cycle check failed");
`define MCDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcds: next-cycle check failed");
`else
`define MCDS_ASSERT_NOW(label, clk, rst, ante, cons)
`define MCDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/mcds_pkg.sv */
// Shared constants, register indexes and the command type of the splitter.
// No dependencies; imported by every module of the block.
package mcds_pkg;

  localparam int MAX_DELIM  = 8;
  localparam int CHAR_WIDTH = 8;
  localparam int LEN_W      = 4;
  localparam int DCHARS_W   = 64;
  localparam int CNT_W      = $clog2(MAX_DELIM + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int IDX_W      = $clog2(MAX_DELIM);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_CHARS  = 1'b1;

  typedef logic [CHAR_WIDTH-1:0] char_t;

  typedef struct packed {
    logic [MAX_DELIM-1:0][CHAR_WIDTH-1:0] chars;
    logic [CNT_W-1:0]                     emit_n;
    logic                                 close;
  } cmd_t;

endpackage

/* rtl/mcds_front.sv */
// Front end: holds back possible delimiter prefixes and classifies each item
// into a release command. Depends on mcds_pkg.
module mcds_front import mcds_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_value,
  input  logic                is_final,
  input  logic [LEN_W-1:0]    delim_length,
  input  logic [DCHARS_W-1:0] delim_chars,
  output cmd_t                cmd
);

  char_t            held [MAX_DELIM-1];
  char_t            held_next [MAX_DELIM-1];
  logic [IDX_W-1:0] held_count;
  logic [IDX_W-1:0] held_count_next;

  always_comb begin
    logic [CNT_W-1:0]     eff_len;
    logic [CNT_W-1:0]     cnt_w;
    logic [CNT_W-1:0]     rem_r;
    logic [CNT_W-1:0]     rel;
    logic [CNT_W-1:0]     rem;
    logic [SUM_W-1:0]     sel;
    logic [MAX_DELIM:0]   ok;
    logic                 match;
    logic                 completed;
    char_t                win [MAX_DELIM];
    char_t                din;

    din = char_value[CHAR_WIDTH-1:0];
    if (delim_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (delim_length > LEN_W'(MAX_DELIM)) begin
      eff_len = CNT_W'(MAX_DELIM);
    end else begin
      eff_len = CNT_W'(delim_length);
    end
    cnt_w = CNT_W'(held_count) + CNT_W'(1);

    for (int i = 0; i < MAX_DELIM - 1; i++) begin
      win[i] = (IDX_W'(i) == held_count) ? din : held[i];
    end
    win[MAX_DELIM-1] = din;

    for (int r = 0; r <= MAX_DELIM; r++) begin
      rem_r = cnt_w - CNT_W'(r);
      match = 1'b1;
      for (int i = 0; i < MAX_DELIM - r; i++) begin
        if (CNT_W'(i) < rem_r &&
            win[r + i] != delim_chars[i*CHAR_WIDTH +: CHAR_WIDTH]) begin
          match = 1'b0;
        end
      end
      if (CNT_W'(r) > cnt_w) begin
        ok[r] = 1'b0;
      end else if (CNT_W'(r) == cnt_w) begin
        ok[r] = 1'b1;
      end else begin
        ok[r] = (rem_r <= eff_len) && match;
      end
    end

    rel = CNT_W'(MAX_DELIM);
    for (int r = MAX_DELIM; r >= 0; r--) begin
      if (ok[r]) begin
        rel = CNT_W'(r);
      end
    end
    rem       = cnt_w - rel;
    completed = (rem == eff_len);

    for (int i = 0; i < MAX_DELIM; i++) begin
      cmd.chars[i] = win[i];
    end
    cmd.emit_n = (is_final && !completed) ? cnt_w : rel;
    cmd.close  = completed || is_final;

    for (int i = 0; i < MAX_DELIM - 1; i++) begin
      sel = SUM_W'(rel) + SUM_W'(i);
      held_next[i] = (sel < SUM_W'(MAX_DELIM)) ? win[sel[IDX_W-1:0]] : '0;
    end
    held_count_next = cmd.close ? '0 : rem[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

endmodule

/* rtl/mcds_queue.sv */
// Short command queue between the front end and the result sequencer.
// Depends on mcds_pkg for the command type and depth.
module mcds_queue import mcds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_cmd;
    end
  end

endmodule

/* rtl/mcds_back.sv */
// Result sequencer: expands each command into token characters and token ends
// through a registered output stage. Depends on mcds_pkg.
module mcds_back import mcds_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       token_end,
  output logic       run_last
);

  logic [CNT_W-1:0] idx;
  logic             token_open;
  logic             advance;
  logic             end_needed;
  logic             ld;
  logic             n_has;
  logic             n_end;
  logic             n_last;
  char_t            n_char;

  assign advance    = !out_valid || out_ready;
  assign end_needed = head.close && (token_open || head.emit_n != '0);

  always_comb begin
    pop    = 1'b0;
    ld     = 1'b0;
    n_has  = 1'b0;
    n_end  = 1'b0;
    n_last = 1'b0;
    n_char = '0;
    if (advance && head_valid) begin
      if (idx < head.emit_n) begin
        ld     = 1'b1;
        n_has  = 1'b1;
        n_char = head.chars[idx[IDX_W-1:0]];
        n_last = (idx + CNT_W'(1) == head.emit_n) && !end_needed;
        pop    = n_last;
      end else if (end_needed) begin
        ld     = 1'b1;
        n_end  = 1'b1;
        n_last = 1'b1;
        pop    = 1'b1;
      end else begin
        pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      idx        <= '0;
      token_open <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= ld;
      end
      if (pop) begin
        idx <= '0;
      end else if (ld) begin
        idx <= idx + CNT_W'(1);
      end
      if (ld && n_has) begin
        token_open <= 1'b1;
      end else if (pop && head.close) begin
        token_open <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ld) begin
      out_char  <= 8'(n_char);
      has_char  <= n_has;
      token_end <= n_end;
      run_last  <= n_last;
    end
  end

endmodule

/* rtl/multi_char_delimiter_splitter.sv */
// Splits a character stream at each leftmost, non-overlapping delimiter.
// Top level; depends on mcds_pkg, mcds_front, mcds_queue, mcds_back and the defines header.
//
// Usage: one character per input item on char_value, with is_final on the
// last character of a string. Results come out one per item: a token
// character (has_char) or a token end (token_end); run_last marks the last
// result caused by an input character. Empty tokens produce nothing.
// The delimiter (delim_length at index 0, delim_chars at index 1) is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. The front end
// takes one character per cycle while the four-entry command queue has room.
// The back end emits one result per cycle while out_ready is high, and a
// character that causes no result still occupies it. The first result of an
// item passes through the command queue and is then registered in the output stage.
// When out_ready is low the output register holds and the queue fills,
// then in_ready drops. Reset empties the queue and the held characters
// and sets the delimiter to one zero character.
`include "multi_char_delimiter_splitter_defines.svh"

module multi_char_delimiter_splitter import mcds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DCHARS_W-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_value,
  input  logic                 is_final,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 has_char,
  output logic                 token_end,
  output logic                 run_last
);

  logic [LEN_W-1:0]    delim_length;
  logic [DCHARS_W-1:0] delim_chars;
  logic                accept;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  cmd_t                front_cmd;
  cmd_t                head_cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_length <= LEN_W'(1);
      delim_chars  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELIM_LENGTH: delim_length <= cfg_data[LEN_W-1:0];
        REG_DELIM_CHARS:  delim_chars  <= cfg_data;
        default:          delim_chars  <= delim_chars;
      endcase
    end
  end

  mcds_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_value   (char_value),
    .is_final     (is_final),
    .delim_length (delim_length),
    .delim_chars  (delim_chars),
    .cmd          (front_cmd)
  );

  mcds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head_cmd)
  );

  mcds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .has_char   (has_char),
    .token_end  (token_end),
    .run_last   (run_last)
  );

  `MCDS_ASSERT_NOW(a_end_is_last, clk, rst, out_valid && token_end, run_last)
  `MCDS_ASSERT_NOW(a_end_no_char, clk, rst, out_valid && token_end, !has_char && out_char == 8'd0)
  `MCDS_ASSERT_NOW(a_result_kind, clk, rst, out_valid, has_char || token_end)
  `MCDS_ASSERT_NEXT(a_burst_gapless, clk, rst, out_valid && out_ready && !run_last, out_valid)

endmodule

/* dv/split_checker.sv */
// Checker for the delimiter splitter: mirrors register writes, predicts the
// token stream from each accepted character and compares every result item.
// Depends on mcds_pkg; instantiated by the testbench beside the block.
module split_checker import mcds_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DCHARS_W-1:0]  cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           char_value,
  input  logic                 is_final,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [7:0]           out_char,
  input  logic                 has_char,
  input  logic                 token_end,
  input  logic                 run_last,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    char_t ch;
    logic  has;
    logic  tend;
    logic  last;
  } token_item_t;

  token_item_t          token_queue[$];
  char_t                held [0:MAX_DELIM-2];
  int                   held_n;
  logic                 tok_open;
  logic [LEN_W-1:0]     delim_len;
  logic [DCHARS_W-1:0]  delim_bytes;

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
  end

  function automatic token_item_t mk_item(char_t c, logic has, logic tend);
    token_item_t t;
    t.ch = c;
    t.has = has;
    t.tend = tend;
    t.last = 1'b0;
    return t;
  endfunction

  task automatic split_char(input char_t c, input logic fin);
    char_t       win [0:MAX_DELIM-1];
    token_item_t run[$];
    int          n;
    int          len;
    int          i;
    logic        match;
    len = (delim_len == 0) ? 1 : ((delim_len > MAX_DELIM) ? MAX_DELIM : int'(delim_len));
    n = held_n;
    for (i = 0; i < n; i++) win[i] = held[i];
    win[n] = c;
    n++;
    // release the oldest character until the window is a delimiter prefix
    while (n > 0) begin
      match = (n <= len);
      for (i = 0; i < n; i++)
        if (win[i] != delim_bytes[CHAR_WIDTH*i +: CHAR_WIDTH]) match = 1'b0;
      if (match) break;
      run = {run, mk_item(win[0], 1'b1, 1'b0)};
      tok_open = 1'b1;
      for (i = 1; i < n; i++) win[i-1] = win[i];
      n--;
    end
    if (n == len) begin
      if (tok_open) run = {run, mk_item('0, 1'b0, 1'b1)};
      tok_open = 1'b0;
      n = 0;
    end
    if (fin) begin
      for (i = 0; i < n; i++) begin
        run = {run, mk_item(win[i], 1'b1, 1'b0)};
        tok_open = 1'b1;
      end
      n = 0;
      if (tok_open) run = {run, mk_item('0, 1'b0, 1'b1)};
      tok_open = 1'b0;
    end
    for (i = 0; i < MAX_DELIM - 1; i++) held[i] = (i < n) ? win[i] : '0;
    held_n = n;
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    token_queue = {token_queue, run};
  endtask

  always @(posedge clk) begin : monitor
    token_item_t got;
    token_item_t want;
    if (rst) begin
      token_queue.delete();
      for (int i = 0; i < MAX_DELIM - 1; i++) held[i] = '0;
      held_n = 0;
      tok_open = 1'b0;
      delim_len = 1;
      delim_bytes = '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DELIM_LENGTH) delim_len = cfg_data[LEN_W-1:0];
        else if (cfg_index == REG_DELIM_CHARS) delim_bytes = cfg_data;
      end
      if (out_valid && out_ready) begin
        got = {out_char, has_char, token_end, run_last};
        checked++;
        if (token_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, got char=%h has=%b end=%b last=%b",
                   $time, got.ch, got.has, got.tend, got.last);
        end else begin
          want = token_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch: expected char=%h has=%b end=%b last=%b",
                     $time, want.ch, want.has, want.tend, want.last);
            $display("%0t:                  got      char=%h has=%b end=%b last=%b",
                     $time, got.ch, got.has, got.tend, got.last);
          end
        end
      end
      if (in_valid && in_ready) split_char(char_value, is_final);
    end
    pending = token_queue.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the delimiter splitter testbench: clock, reset, register writes,
// character strings and output stalls, plus the watchdog and the verdict.
// Depends on mcds_pkg, multi_char_delimiter_splitter and split_checker.
module testbench;
  import mcds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int NPHASE      = 8;
  localparam int PHASE_ITEMS = 46;
  localparam int SETTLE      = 16;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DCHARS_W-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           char_value = '0;
  logic                 is_final = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_char;
  logic                 has_char;
  logic                 token_end;
  logic                 run_last;
  int                   fail_count;
  int                   pending;
  int                   checked;

  int                   cur_len = 1;
  logic [DCHARS_W-1:0]  cur_bytes = '0;
  int                   items_sent = 0;
  int                   strings_sent = 0;
  int                   settings_used = 0;
  int                   stall_cycles = 0;
  bit                   tx_quiet = 1'b0;
  bit                   rx_quiet = 1'b0;

  multi_char_delimiter_splitter DUT (.*);
  split_checker checker_i (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, stall_cycles);
        $display("multi_char_delimiter_splitter test failed");
        $finish;
      end
    end
  end

  task automatic send_char(input char_t c, input logic fin);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    char_value <= c;
    is_final <= fin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_delim(input int len, input logic [DCHARS_W-1:0] bytes);
    cfg_we <= 1'b1;
    cfg_index <= REG_DELIM_LENGTH;
    cfg_data <= DCHARS_W'(len);
    @(negedge clk);
    cfg_index <= REG_DELIM_CHARS;
    cfg_data <= bytes;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_len = len;
    cur_bytes = bytes;
    settings_used++;
  endtask

  task automatic send_string(input int alpha);
    char_t str[$];
    int    nseg;
    int    sel;
    int    plen;
    nseg = $urandom_range(1, 6);
    for (int s = 0; s < nseg; s++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        plen = (sel < 30) ? cur_len : $urandom_range(1, cur_len);
        for (int i = 0; i < plen; i++) str = {str, char_t'(cur_bytes[8*i +: 8])};
      end else if (sel < 80) begin
        str = {str, char_t'(alpha + $urandom_range(0, 2))};
      end else begin
        str = {str, char_t'($urandom_range(0, 255))};
      end
    end
    for (int i = 0; i < str.size(); i++) send_char(str[i], i == str.size() - 1);
    strings_sent++;
  endtask

  initial begin : receiver
    int k;
    int taken;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (taken == 150) begin
        k = 120;
      end else begin
        k = rx_quiet ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      end
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int                  len;
    int                  alpha;
    int                  phase_start;
    logic [DCHARS_W-1:0] bytes;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset delimiter: a single zero character
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'h42, 1'b0);
    send_char(8'h00, 1'b1);

    // longest delimiter broken on its last character: full release burst
    drain();
    set_delim(8, '1);
    for (int i = 0; i < 7; i++) send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);

    // partial match that slips by one, then a held prefix left open
    drain();
    set_delim(3, 64'h62_61_61);
    send_char(8'h61, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h63, 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h61, 1'b0);

    // change the delimiter while characters are still held
    drain();
    set_delim(1, 64'hFFFF_FFFF_FFFF_FF61);
    send_char(8'h7A, 1'b1);

    for (int p = 0; p < NPHASE; p++) begin
      drain();
      len = (p == 0) ? 1 : ((p == 1 || p == NPHASE - 1) ? 8 : $urandom_range(1, 8));
      alpha = $urandom_range(0, 253);
      for (int b = 0; b < 8; b++)
        bytes[8*b +: 8] = ($urandom_range(0, 9) < 6) ? char_t'(alpha + $urandom_range(0, 2))
                                                     : char_t'($urandom_range(0, 255));
      if (p == 2) bytes = {8{char_t'(alpha)}};
      if (p == 3) bytes = '0;
      if (p == NPHASE - 1) bytes = '1;
      set_delim(len, bytes);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_string(alpha);
    end

    drain();
    $display("Sent %0d characters (%0d random strings) under %0d delimiter settings.",
             items_sent, strings_sent, settings_used);
    $display("Checked %0d results against the predicted token stream.", checked);
    if (fail_count == 0 && pending == 0)
      $display("multi_char_delimiter_splitter test passed");
    else
      $display("multi_char_delimiter_splitter test failed");
    $finish;
  end

endmodule
